[rtl/timer_min_heap_queue_assert.svh]
// Assertion macros for the timer heap queue.
`ifndef TIMER_MIN_HEAP_QUEUE_ASSERT_SVH
`define TIMER_MIN_HEAP_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMHQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TMHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TMHQ_ASSERT_IMPL(label, ante, cons)
`define TMHQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/tmhq_pkg.sv]
//------------------------------------------------------------------------------
// Timer heap queue package
// Shared widths, command and status codes.
//------------------------------------------------------------------------------
package tmhq_pkg;
  localparam int HeapDepth = 64;
  localparam int TimeBits = 48;
  localparam int SlotBits = 7;
  localparam int IdBits = 6;
  localparam int PerBits = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_RESTART = 3'd2, CMD_POP = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_QUEUED = 3'd1, ST_NOT_QUEUED = 3'd2, ST_FULL = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // Saturating add of an interval to the current time.
  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] a,
                                                  input logic [PerBits-1:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {{(TimeBits+1-PerBits){1'b0}}, b};
    return s[TimeBits] ? {TimeBits{1'b1}} : s[TimeBits-1:0];
  endfunction
endpackage

[rtl/timer_min_heap_queue.sv]
//------------------------------------------------------------------------------
// Timer min-heap queue
// Binary min-heap of 64 timers keyed on expiry, held in block memories.
//------------------------------------------------------------------------------
// Busy is high from the transfer until the result; done follows in the next
// cycle. A downward sift steps S_DNR, S_DNR2, S_DNC per level, an upward one
// S_UPR, S_UPC; a six-level restart or a pop of a near-full heap is worst case.
// Throughput: one command at a time; the next may transfer while done is high.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset clears the slot map valid bits and the entry count at once.
`include "timer_min_heap_queue_assert.svh"
module timer_min_heap_queue import tmhq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          cmd,
  input  logic [IdBits-1:0]   timer_id,
  input  logic [PerBits-1:0]  interval_us,
  input  logic [TimeBits-1:0] now_us,
  output logic                done,
  output logic [2:0]          status,
  output logic [IdBits-1:0]   popped_id,
  output logic                top_valid,
  output logic [IdBits-1:0]   top_id,
  output logic                top_expired,
  output logic [TimeBits-1:0] top_remaining_us
);
  localparam int AW = IdBits;
  localparam int EW = TimeBits + IdBits;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001, S_LOOK = 12'b000000000010,
    S_DEC  = 12'b000000000100, S_RDL  = 12'b000000001000,
    S_HOLE = 12'b000000010000, S_UPR  = 12'b000000100000,
    S_UPC  = 12'b000001000000, S_DNR  = 12'b000010000000,
    S_DNR2 = 12'b000100000000, S_DNC  = 12'b001000000000,
    S_TOP  = 12'b010000000000, S_OUT  = 12'b100000000000
  } state_t;

  state_t state;
  logic [2:0] c_cmd;
  logic [IdBits-1:0] c_id;
  logic [PerBits-1:0] c_int;
  logic [TimeBits-1:0] c_now;
  logic [SlotBits-1:0] count;
  logic [SlotBits-1:0] idx, hole, kid;
  logic [TimeBits-1:0] m_exp;
  logic [IdBits-1:0] m_own;
  logic [TimeBits-1:0] l_exp;
  logic [2:0] st;
  logic [IdBits-1:0] pop_id;
  logic up_mode;
  logic [HeapDepth-1:0] map_valid;

  // Heap memory: expiry and owner per slot (slot-1 as address).
  logic h_we;
  logic [AW-1:0] h_wa, h_ra;
  logic [EW-1:0] h_wd, h_rd;
  tmhq_ram #(.Width(EW), .Depth(HeapDepth)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  // Slot map memory.
  logic m_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [SlotBits-1:0] m_wd, m_rd;
  tmhq_ram #(.Width(SlotBits), .Depth(HeapDepth)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  // Period memory.
  logic p_we;
  logic [PerBits-1:0] p_rd;
  tmhq_ram #(.Width(PerBits), .Depth(HeapDepth)) u_per (
    .clk(clk), .we(p_we), .waddr(c_id), .wdata(c_int), .raddr(c_id), .rdata(p_rd));

  // A second read copy of the heap for the sibling read.
  logic [EW-1:0] h2_rd;
  logic [AW-1:0] h2_ra;
  tmhq_ram #(.Width(EW), .Depth(HeapDepth)) u_heap2 (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h2_ra), .rdata(h2_rd));

  logic [SlotBits-1:0] slot_q;
  logic queued;
  logic [TimeBits-1:0] r_exp, r2_exp;
  logic [SlotBits-1:0] lchild;
  logic [SlotBits:0] lchild_w;

  assign slot_q = map_valid[c_id] ? m_rd : '0;
  assign queued = (slot_q != '0) && (slot_q <= count);
  assign r_exp = h_rd[EW-1:IdBits];
  assign r2_exp = h2_rd[EW-1:IdBits];
  assign lchild_w = {idx, 1'b0};
  assign lchild = lchild_w[SlotBits-1:0];
  assign busy = (state != S_IDLE);

  function automatic logic [AW-1:0] a_of(input logic [SlotBits-1:0] s);
    logic [SlotBits-1:0] t;
    t = s - 1'b1;
    return t[AW-1:0];
  endfunction

  // Memory port control.
  always_comb begin
    h_we = 1'b0; h_wa = a_of(idx); h_wd = {m_exp, m_own};
    h_ra = a_of(idx); h2_ra = a_of(idx);
    m_we = 1'b0; m_wa = m_own; m_wd = idx; m_ra = c_id;
    p_we = 1'b0;
    case (state)
      S_IDLE: m_ra = timer_id;
      S_DEC: begin h_ra = a_of(count); h2_ra = '0; end
      S_RDL: begin
        h_ra = a_of(count);
        // The removed timer leaves the heap, so its slot map entry goes to zero.
        if (c_cmd != CMD_RESTART) begin
          m_we = 1'b1; m_wd = '0;
          m_wa = (c_cmd == CMD_POP) ? h2_rd[IdBits-1:0] : c_id;
        end
      end
      S_HOLE: h_ra = a_of({1'b0, hole[SlotBits-1:1]});
      S_UPR: h_ra = a_of({1'b0, idx[SlotBits-1:1]});
      S_UPC: begin
        if (idx != 7'd1 && r_exp >= m_exp) begin
          h_we = 1'b1; h_wd = h_rd; m_we = 1'b1; m_wa = h_rd[IdBits-1:0];
        end else begin
          h_we = 1'b1; m_we = 1'b1;
        end
      end
      S_DNR, S_DNR2: begin h_ra = a_of(lchild); h2_ra = a_of(lchild + 1'b1); end
      S_DNC: begin
        if (idx <= {1'b0, count[SlotBits-1:1]} &&
            !(((kid == lchild) ? r_exp : r2_exp) > m_exp)) begin
          h_we = 1'b1;
          h_wd = (kid == lchild) ? h_rd : h2_rd;
          m_we = 1'b1;
          m_wa = (kid == lchild) ? h_rd[IdBits-1:0] : h2_rd[IdBits-1:0];
        end else begin
          h_we = 1'b1; m_we = 1'b1;
        end
      end
      S_TOP: h_ra = '0;
      default: ;
    endcase
    if (state == S_LOOK && c_cmd == CMD_ADD && !queued && count < SlotBits'(HeapDepth))
      p_we = 1'b1;
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      map_valid <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      if (m_we) map_valid[m_wa] <= 1'b1;
      case (state)
        S_IDLE: if (start) begin
          c_cmd <= cmd; c_id <= timer_id; c_int <= interval_us; c_now <= now_us;
          st <= ST_OK; pop_id <= '0; state <= S_LOOK;
        end
        S_LOOK: begin
          hole <= (c_cmd == CMD_POP) ? 7'd1 : slot_q;
          case (c_cmd)
            CMD_ADD: begin
              if (queued) begin st <= ST_QUEUED; state <= S_TOP; end
              else if (count >= SlotBits'(HeapDepth)) begin
                st <= ST_FULL; state <= S_TOP;
              end else begin
                m_exp <= sat_add(c_now, c_int); m_own <= c_id;
                idx <= count + 1'b1; count <= count + 1'b1;
                up_mode <= 1'b1; state <= S_UPR;
              end
            end
            CMD_REMOVE, CMD_RESTART: begin
              if (!queued) begin st <= ST_NOT_QUEUED; state <= S_TOP; end
              else state <= (c_cmd == CMD_REMOVE) ? S_DEC : S_RDL;
            end
            CMD_POP: begin
              if (count == '0) begin st <= ST_EMPTY; state <= S_TOP; end
              else state <= S_DEC;
            end
            default: state <= S_TOP;
          endcase
        end
        S_DEC: begin
          // Last entry and top entry are being read; drop the count.
          count <= count - 1'b1;
          state <= S_RDL;
        end
        S_RDL: begin
          if (c_cmd == CMD_RESTART) begin
            // Period read is ready; hole is the timer's own slot.
            m_exp <= sat_add(c_now, p_rd); m_own <= c_id; idx <= hole;
            state <= S_DNR;
          end else begin
            if (c_cmd == CMD_POP) pop_id <= h2_rd[IdBits-1:0];
            l_exp <= r_exp;
            m_exp <= r_exp; m_own <= h_rd[IdBits-1:0];
            idx <= hole;
            if (hole > count) state <= S_TOP;
            else state <= S_HOLE;
          end
        end
        S_HOLE: begin
          // Parent of the hole is being read.
          state <= S_UPR;
          up_mode <= 1'b0;
        end
        S_UPR: begin
          if (!up_mode) begin
            // The parent read from S_HOLE is valid here, so compare it now.
            if (idx > 7'd1 && r_exp > l_exp) begin
              up_mode <= 1'b1; state <= S_UPC;
            end else state <= S_DNR;
          end else state <= S_UPC;
        end
        S_UPC: begin
          if (idx != 7'd1 && r_exp >= m_exp) begin
            idx <= {1'b0, idx[SlotBits-1:1]}; state <= S_UPR;
          end else state <= S_TOP;
        end
        S_DNR: state <= S_DNR2;
        S_DNR2: begin
          if ({1'b0, lchild} + 1'b1 <= {1'b0, count} && r_exp > r2_exp)
            kid <= lchild + 1'b1;
          else kid <= lchild;
          state <= S_DNC;
        end
        S_DNC: begin
          if (idx <= {1'b0, count[SlotBits-1:1]} &&
              !(((kid == lchild) ? r_exp : r2_exp) > m_exp)) begin
            idx <= kid; state <= S_DNR;
          end else state <= S_TOP;
        end
        S_TOP: state <= S_OUT;
        S_OUT: begin
          status <= st;
          popped_id <= pop_id;
          top_valid <= (count != '0);
          top_id <= (count != '0) ? h_rd[IdBits-1:0] : '0;
          top_expired <= (count != '0) && (r_exp <= c_now);
          top_remaining_us <= (count != '0 && r_exp > c_now) ? r_exp - c_now : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMHQ_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `TMHQ_ASSERT_IMPL(a_done_idle, done, !busy)
  `TMHQ_ASSERT_IMPL(a_count_max, 1'b1, count <= SlotBits'(HeapDepth))
endmodule

[rtl/tmhq_ram.sv]
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
//------------------------------------------------------------------------------
module tmhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[tb/tb_timer_min_heap_queue.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Timer heap queue testbench
// Drives add, remove, restart, pop and query commands into the timer heap,
// keeps its own heap model to predict each result, and compares every result
// field by field. A directed table comes first, then a heap fill, then random traffic.
//------------------------------------------------------------------------------
module tb_timer_min_heap_queue;
  import tmhq_pkg::*;

  localparam int NumTimers = 64;
  localparam longint CycleLimit = 400000;
  localparam int RandomItems = 440;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  typedef struct {
    logic [2:0]          cmd;
    logic [IdBits-1:0]   id;
    logic [PerBits-1:0]  interval;
    logic [TimeBits-1:0] now;
  } heap_cmd_t;

  typedef struct {
    logic [2:0]          status;
    logic [IdBits-1:0]   popped;
    logic                top_valid;
    logic [IdBits-1:0]   top_id;
    logic                top_expired;
    logic [TimeBits-1:0] top_remaining;
  } heap_result_t;

  // Directed row: a command plus an optional typed-in expected status.
  typedef struct {
    heap_cmd_t   c;
    bit          has_status;
    logic [2:0]  status;
  } table_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [2:0]          cmd;
  logic [IdBits-1:0]   timer_id;
  logic [PerBits-1:0]  interval_us;
  logic [TimeBits-1:0] now_us;
  logic                done;
  logic [2:0]          status;
  logic [IdBits-1:0]   popped_id;
  logic                top_valid;
  logic [IdBits-1:0]   top_id;
  logic                top_expired;
  logic [TimeBits-1:0] top_remaining_us;

  timer_min_heap_queue DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .timer_id(timer_id), .interval_us(interval_us), .now_us(now_us),
    .done(done), .status(status), .popped_id(popped_id), .top_valid(top_valid),
    .top_id(top_id), .top_expired(top_expired), .top_remaining_us(top_remaining_us)
  );

  // Predictor state.
  logic [TimeBits-1:0] pexp [1:HeapDepth];
  logic [IdBits-1:0]   powner [1:HeapDepth];
  int                  pslot [NumTimers];
  logic [PerBits-1:0]  pperiod [NumTimers];
  int                  pcount;

  heap_result_t pending_results[$];
  int  errors;
  int  transfers;
  int  results_seen;
  int  pops_ok;
  longint cycles;
  logic [TimeBits-1:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TimeBits-1:0] expiry_of(logic [TimeBits-1:0] t,
                                                    logic [PerBits-1:0] iv);
    logic [TimeBits:0] s;
    s = {1'b0, t} + iv;
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction

  function automatic void put_slot(int s, logic [TimeBits-1:0] e, logic [IdBits-1:0] o);
    pexp[s] = e;
    powner[s] = o;
    pslot[o] = s;
  endfunction

  function automatic void heap_sift_up(int idx);
    logic [TimeBits-1:0] e;
    logic [IdBits-1:0] o;
    int par;
    e = pexp[idx];
    o = powner[idx];
    par = idx >> 1;
    while (par != 0 && pexp[par] >= e) begin
      put_slot(idx, pexp[par], powner[par]);
      idx = par;
      par = par >> 1;
    end
    put_slot(idx, e, o);
  endfunction

  function automatic void heap_sift_down(int idx);
    logic [TimeBits-1:0] e;
    logic [IdBits-1:0] o;
    int ch;
    e = pexp[idx];
    o = powner[idx];
    while (idx <= (pcount >> 1)) begin
      ch = idx << 1;
      if (ch + 1 <= pcount && pexp[ch] > pexp[ch + 1]) ch++;
      if (pexp[ch] > e) break;
      put_slot(idx, pexp[ch], powner[ch]);
      idx = ch;
    end
    put_slot(idx, e, o);
  endfunction

  function automatic void heap_take(int s, logic [IdBits-1:0] id);
    pexp[s] = pexp[pcount];
    powner[s] = powner[pcount];
    pcount--;
    pslot[id] = 0;
    if (s <= pcount) begin
      if (s > 1 && pexp[s >> 1] > pexp[s]) heap_sift_up(s);
      else heap_sift_down(s);
    end
  endfunction

  // Applies one command to the heap model and returns the expected result.
  function automatic heap_result_t heap_apply(heap_cmd_t c);
    heap_result_t r;
    int s;
    bit queued;
    logic [IdBits-1:0] topo;
    s = pslot[c.id];
    queued = s != 0 && s <= pcount;
    r.status = ST_OK;
    r.popped = '0;
    case (c.cmd)
      CMD_ADD: begin
        if (queued) r.status = ST_QUEUED;
        else if (pcount >= HeapDepth) r.status = ST_FULL;
        else begin
          pperiod[c.id] = c.interval;
          pcount++;
          put_slot(pcount, expiry_of(c.now, c.interval), c.id);
          heap_sift_up(pcount);
        end
      end
      CMD_REMOVE: begin
        if (!queued) r.status = ST_NOT_QUEUED;
        else heap_take(s, c.id);
      end
      CMD_RESTART: begin
        if (!queued) r.status = ST_NOT_QUEUED;
        else begin
          pexp[s] = expiry_of(c.now, pperiod[c.id]);
          heap_sift_down(s);
        end
      end
      CMD_POP: begin
        if (pcount == 0) r.status = ST_EMPTY;
        else begin
          topo = powner[1];
          r.popped = topo;
          heap_take(1, topo);
        end
      end
      default: ;
    endcase
    if (pcount != 0) begin
      r.top_valid = 1'b1;
      r.top_id = powner[1];
      r.top_expired = pexp[1] <= c.now;
      r.top_remaining = (pexp[1] > c.now) ? pexp[1] - c.now : '0;
    end else begin
      r.top_valid = 1'b0;
      r.top_id = '0;
      r.top_expired = 1'b0;
      r.top_remaining = '0;
    end
    return r;
  endfunction

  // Result checker: every strobed result is matched to the oldest prediction.
  always @(posedge clk) begin
    heap_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status); errors++;
        end
        if (popped_id !== e.popped) begin
          $error("popped_id expected %0d actual %0d", e.popped, popped_id); errors++;
        end
        if (top_valid !== e.top_valid) begin
          $error("top_valid expected %0d actual %0d", e.top_valid, top_valid); errors++;
        end
        if (top_id !== e.top_id) begin
          $error("top_id expected %0d actual %0d", e.top_id, top_id); errors++;
        end
        if (top_expired !== e.top_expired) begin
          $error("top_expired expected %0d actual %0d", e.top_expired, top_expired);
          errors++;
        end
        if (top_remaining_us !== e.top_remaining) begin
          $error("top_remaining_us expected %0d actual %0d", e.top_remaining,
                 top_remaining_us);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Drops start for a random number of cycles; a zero gap keeps it high.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Presents one command at the falling edge and holds it until the transfer.
  task automatic send_cmd(heap_cmd_t c, bit has_status, logic [2:0] want);
    heap_result_t r;
    cmd <= c.cmd;
    timer_id <= c.id;
    interval_us <= c.interval;
    now_us <= c.now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = heap_apply(c);
    if (has_status && r.status !== want) begin
      $error("table status expected %0d predicted %0d", want, r.status);
      errors++;
    end
    if (c.cmd == CMD_POP && r.status == ST_OK) pops_ok++;
    pending_results.push_back(r);
    transfers++;
    @(negedge clk);
  endtask

  function automatic heap_cmd_t mk(logic [2:0] k, int id, logic [PerBits-1:0] iv,
                                   logic [TimeBits-1:0] t);
    heap_cmd_t c;
    c.cmd = k; c.id = id[IdBits-1:0]; c.interval = iv; c.now = t;
    return c;
  endfunction

  // Random command biased toward a busy heap with small time steps.
  function automatic heap_cmd_t random_cmd();
    heap_cmd_t c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) c.cmd = CMD_ADD;
    else if (p < 55) c.cmd = CMD_REMOVE;
    else if (p < 70) c.cmd = CMD_RESTART;
    else if (p < 88) c.cmd = CMD_POP;
    else if (p < 95) c.cmd = CMD_QUERY;
    else c.cmd = 3'($urandom_range(5, 7));
    c.id = IdBits'($urandom_range(0, NumTimers - 1));
    case ($urandom_range(0, 9))
      0: c.interval = $urandom();
      1: c.interval = '1;
      2: c.interval = '0;
      default: c.interval = $urandom_range(0, 2000);
    endcase
    if ($urandom_range(0, 49) == 0) begin
      clock_now = TimeBits'({$urandom(), $urandom()});
    end else if ($urandom_range(0, 3) != 0) begin
      clock_now = clock_now + $urandom_range(0, 300);
    end
    c.now = clock_now;
    return c;
  endfunction

  initial begin
    table_row_t rows[$];
    heap_cmd_t c;
    int i;
    errors = 0; transfers = 0; results_seen = 0; pops_ok = 0; cycles = 0;
    pcount = 0;
    for (i = 0; i < NumTimers; i++) begin
      pslot[i] = 0;
      pperiod[i] = '0;
    end
    rst = 1'b1; start = 1'b0; cmd = CMD_QUERY; timer_id = '0; interval_us = '0;
    now_us = '0;
    clock_now = 48'd1000;

    // Directed table: empty-heap errors, extremes, ties and saturation.
    rows.push_back('{mk(CMD_POP, 0, 0, 0), 1, ST_EMPTY});
    rows.push_back('{mk(CMD_QUERY, 0, 0, 0), 1, ST_OK});
    rows.push_back('{mk(CMD_REMOVE, 5, 0, 0), 1, ST_NOT_QUEUED});
    rows.push_back('{mk(CMD_RESTART, 63, 0, 0), 1, ST_NOT_QUEUED});
    rows.push_back('{mk(CMD_ADD, 0, 0, 0), 1, ST_OK});
    rows.push_back('{mk(CMD_ADD, 0, 5, 0), 1, ST_QUEUED});
    rows.push_back('{mk(CMD_ADD, 63, 32'hFFFF_FFFF, TimeMax), 1, ST_OK});
    rows.push_back('{mk(CMD_ADD, 21, 32'hFFFF_FFFF, TimeMax - 10), 0, 0});
    rows.push_back('{mk(CMD_ADD, 42, 100, 50), 0, 0});
    rows.push_back('{mk(CMD_ADD, 7, 100, 50), 0, 0});
    rows.push_back('{mk(CMD_ADD, 8, 150, 0), 0, 0});
    rows.push_back('{mk(CMD_QUERY, 0, 0, 120), 0, 0});
    rows.push_back('{mk(CMD_RESTART, 0, 0, 500), 0, 0});
    rows.push_back('{mk(CMD_REMOVE, 42, 0, 500), 0, 0});
    rows.push_back('{mk(5, 0, 0, 160), 1, ST_OK});
    rows.push_back('{mk(7, 0, 0, 160), 1, ST_OK});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 0, 0});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 0, 0});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 0, 0});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 0, 0});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 0, 0});
    rows.push_back('{mk(CMD_POP, 0, 0, 200), 1, ST_EMPTY});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) begin
      send_cmd(rows[k].c, rows[k].has_status, rows[k].status);
      idle_gap();
    end

    // Fill the heap completely, exercise the queued checks on a full heap,
    // then drain part of it.
    for (i = 0; i < NumTimers; i++) begin
      send_cmd(mk(CMD_ADD, i, $urandom_range(0, 500), clock_now), 0, 0);
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
    send_cmd(mk(CMD_ADD, 9, 0, clock_now), 1, ST_QUEUED);
    send_cmd(mk(CMD_REMOVE, 30, 0, clock_now), 1, ST_OK);
    send_cmd(mk(CMD_ADD, 30, 3, clock_now), 1, ST_OK);
    send_cmd(mk(CMD_ADD, 30, 3, clock_now), 1, ST_QUEUED);
    send_cmd(mk(CMD_REMOVE, 31, 0, clock_now), 1, ST_OK);
    send_cmd(mk(CMD_ADD, 31, 3, clock_now), 1, ST_OK);
    send_cmd(mk(CMD_ADD, 0, 0, clock_now), 1, ST_QUEUED);
    for (i = 0; i < 20; i++) send_cmd(mk(CMD_POP, 0, 0, clock_now + i * 50), 0, 0);

    // Random traffic; some stretches run back to back.
    for (i = 0; i < RandomItems; i++) begin
      c = random_cmd();
      send_cmd(c, 0, 0);
      if ((i / 60) % 3 != 2) idle_gap();
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d commands transferred, %0d results checked, %0d successful pops.",
             transfers, results_seen, pops_ok);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/tmhq_pkg.sv
rtl/tmhq_ram.sv
rtl/timer_min_heap_queue.sv
tb/tb_timer_min_heap_queue.sv
